// ===== rtl/mi4_pkg.sv =====
// Shared types, constants and helpers for the 4x4 matrix inverse block.
// Used by mi4_ctrl, mi4_dp and the top level; depends on nothing.
package mi4_pkg;

	localparam int ELEM_W            = 32;
	localparam int WIDE_W            = 61;
	localparam int MAG_W             = 60;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [MAG_W-1:0] MAG_LIM = '1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RDA,
		S_RDB,
		S_MUL0,
		S_MUL1,
		S_SUM,
		S_RND,
		S_ACC,
		S_OSTART,
		S_DIV,
		S_OWAIT
	} state_t;

	typedef enum logic [1:0] {
		PH_MIN,
		PH_DET,
		PH_AFF,
		PH_OUT
	} phase_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RDA,
		OP_RDB,
		OP_MUL0,
		OP_MUL1,
		OP_SUM,
		OP_RND,
		OP_ACC,
		OP_DIV,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		B_ELEM,
		B_ACC0,
		B_COF
	} bsrc_t;

	typedef enum logic [1:0] {
		T_ACC0,
		T_ACC1,
		T_DET
	} tgt_t;

	typedef enum logic [1:0] {
		A_SET,
		A_ADD,
		A_SUB
	} amode_t;

	typedef struct packed {
		logic       wr;
		op_t        op;
		logic [3:0] addr;
		bsrc_t      bsrc;
		tgt_t       tgt;
		amode_t     amode;
		logic [3:0] cidx;
		logic       cof_we;
		logic       cflip;
		logic [3:0] k;
		logic       aff;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	// element address of entry k of the 3x3 minor that drops row r and column c
	function automatic logic [3:0] maddr(logic [1:0] r, logic [1:0] c, logic [3:0] k);
		logic [1:0] y;
		logic [1:0] x;
		logic [1:0] ry;
		logic [1:0] cx;
		y  = (k >= 4'd6) ? 2'd2 : ((k >= 4'd3) ? 2'd1 : 2'd0);
		x  = 2'(k - 4'(y) * 4'd3);
		ry = (y < r) ? y : 2'(y + 2'd1);
		cx = (x < c) ? x : 2'(x + 2'd1);
		return {ry, cx};
	endfunction

endpackage

// ===== rtl/matrix_inverse_4x4.sv =====
// 4x4 fixed-point matrix inverse, top level; depends on mi4_pkg, mi4_ctrl, mi4_dp.
// Loads accept one element per cycle. General mode: 16 minors of 9 products and the
// determinant of 4 on the shared multiplier, each product read, multiplied in two halves,
// summed, rounded and accumulated, then per result a bit-serial division of a
// 60+FRACTION_BITS-bit numerator by the determinant magnitude.
// Asynchronous active-low reset clears the sequencer, load count and mode to general.
module matrix_inverse_4x4 #(
	parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] element,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [1:0]         row,
	output logic [1:0]         column,
	output logic signed [31:0] determinant,
	output logic               singular,
	output logic               last
);

	mi4_pkg::cmd_t    cmd;
	mi4_pkg::status_t status;

	mi4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mi4_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.element     (element),
		.cmd         (cmd),
		.status      (status),
		.value       (value),
		.row         (row),
		.column      (column),
		.determinant (determinant),
		.singular    (singular),
		.last        (last)
	);

endmodule

// ===== rtl/mi4_ctrl.sv =====
// Controller of the 4x4 matrix inverse: load count, mode register, sequencer.
// Depends on mi4_pkg; drives mi4_dp through cmd_t and reads status_t.
module mi4_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	input  mi4_pkg::status_t status,
	output mi4_pkg::cmd_t    cmd
);

	mi4_pkg::state_t state_q, state_d;
	mi4_pkg::phase_t phase_q, phase_d;
	logic [3:0] cnt_q, cnt_d;
	logic [3:0] mi_q, mi_d;
	logic [1:0] t_q, t_d;
	logic [1:0] s_q, s_d;
	logic       mode_q;
	logic       aff_q, aff_d;
	logic       out_valid_q, out_valid_d;

	logic [1:0] r, c;
	logic [3:0] p3, q3;
	logic [3:0] a_addr, b_addr;
	mi4_pkg::bsrc_t  bsrc;
	mi4_pkg::tgt_t   tgt;
	mi4_pkg::amode_t amode;
	logic       cof_we;
	logic       out_free;

	assign in_ready  = (state_q == mi4_pkg::S_LOAD);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mi4_pkg::S_LOAD;
			phase_q     <= mi4_pkg::PH_MIN;
			cnt_q       <= '0;
			mi_q        <= '0;
			t_q         <= '0;
			s_q         <= '0;
			mode_q      <= 1'b0;
			aff_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			mi_q        <= mi_d;
			t_q         <= t_d;
			s_q         <= s_d;
			aff_q       <= aff_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
		end
	end

	// operand addresses and accumulate control for the current product
	always_comb begin
		r      = mi_q[3:2];
		c      = mi_q[1:0];
		p3     = (t_q == 2'd0) ? 4'd1 : 4'd0;
		q3     = (t_q == 2'd2) ? 4'd1 : 4'd2;
		a_addr = '0;
		b_addr = '0;
		bsrc   = mi4_pkg::B_ELEM;
		tgt    = mi4_pkg::T_ACC0;
		amode  = mi4_pkg::A_SET;
		cof_we = 1'b0;
		unique case (phase_q)
			mi4_pkg::PH_MIN: begin
				case (s_q)
					2'd0: begin
						a_addr = mi4_pkg::maddr(r, c, 4'(4'd3 + p3));
						b_addr = mi4_pkg::maddr(r, c, 4'(4'd6 + q3));
					end
					2'd1: begin
						a_addr = mi4_pkg::maddr(r, c, 4'(4'd3 + q3));
						b_addr = mi4_pkg::maddr(r, c, 4'(4'd6 + p3));
						amode  = mi4_pkg::A_SUB;
					end
					default: begin
						a_addr = mi4_pkg::maddr(r, c, {2'b00, t_q});
						bsrc   = mi4_pkg::B_ACC0;
						tgt    = mi4_pkg::T_ACC1;
						amode  = (t_q == 2'd0) ? mi4_pkg::A_SET :
							((t_q == 2'd1) ? mi4_pkg::A_SUB : mi4_pkg::A_ADD);
						cof_we = (t_q == 2'd2);
					end
				endcase
			end
			mi4_pkg::PH_DET: begin
				a_addr = {2'b00, mi_q[1:0]};
				bsrc   = mi4_pkg::B_COF;
				tgt    = mi4_pkg::T_DET;
				amode  = (mi_q[1:0] == 2'd0) ? mi4_pkg::A_SET :
					(mi_q[0] ? mi4_pkg::A_SUB : mi4_pkg::A_ADD);
			end
			mi4_pkg::PH_AFF: begin
				a_addr = {s_q, 2'b11};
				b_addr = {s_q, r};
				amode  = (s_q == 2'd0) ? mi4_pkg::A_SET : mi4_pkg::A_ADD;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		mi_d        = mi_q;
		t_d         = t_q;
		s_d         = s_q;
		aff_d       = aff_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.op      = mi4_pkg::OP_NONE;
		cmd.bsrc    = bsrc;
		cmd.tgt     = tgt;
		cmd.amode   = amode;
		cmd.cidx    = mi_q;
		cmd.k       = mi_q;
		cmd.aff     = aff_q;
		cmd.cflip   = mi_q[2] ^ mi_q[0];
		unique case (state_q)
			mi4_pkg::S_LOAD: begin
				cmd.addr = cnt_q;
				cmd.wr   = in_valid;
				if (in_valid) begin
					cnt_d = 4'(cnt_q + 4'd1);
					if (cnt_q == 4'd15) begin
						aff_d   = mode_q;
						mi_d    = '0;
						t_d     = '0;
						s_d     = '0;
						phase_d = mode_q ? mi4_pkg::PH_AFF : mi4_pkg::PH_MIN;
						state_d = mode_q ? mi4_pkg::S_OSTART : mi4_pkg::S_RDA;
					end
				end
			end
			mi4_pkg::S_RDA: begin
				cmd.op   = mi4_pkg::OP_RDA;
				cmd.addr = a_addr;
				state_d  = mi4_pkg::S_RDB;
			end
			mi4_pkg::S_RDB: begin
				cmd.op   = mi4_pkg::OP_RDB;
				cmd.addr = b_addr;
				state_d  = mi4_pkg::S_MUL0;
			end
			mi4_pkg::S_MUL0: begin
				cmd.op  = mi4_pkg::OP_MUL0;
				state_d = mi4_pkg::S_MUL1;
			end
			mi4_pkg::S_MUL1: begin
				cmd.op  = mi4_pkg::OP_MUL1;
				state_d = mi4_pkg::S_SUM;
			end
			mi4_pkg::S_SUM: begin
				cmd.op  = mi4_pkg::OP_SUM;
				state_d = mi4_pkg::S_RND;
			end
			mi4_pkg::S_RND: begin
				cmd.op  = mi4_pkg::OP_RND;
				state_d = mi4_pkg::S_ACC;
			end
			mi4_pkg::S_ACC: begin
				cmd.op     = mi4_pkg::OP_ACC;
				cmd.cof_we = cof_we;
				state_d    = mi4_pkg::S_RDA;
				unique case (phase_q)
					mi4_pkg::PH_MIN: begin
						if (s_q == 2'd2) begin
							s_d = '0;
							if (t_q == 2'd2) begin
								t_d = '0;
								if (mi_q == 4'd15) begin
									phase_d = mi4_pkg::PH_DET;
									mi_d    = '0;
								end else begin
									mi_d = 4'(mi_q + 4'd1);
								end
							end else begin
								t_d = 2'(t_q + 2'd1);
							end
						end else begin
							s_d = 2'(s_q + 2'd1);
						end
					end
					mi4_pkg::PH_DET: begin
						if (mi_q == 4'd3) begin
							phase_d = mi4_pkg::PH_OUT;
							mi_d    = '0;
							state_d = mi4_pkg::S_OSTART;
						end else begin
							mi_d = 4'(mi_q + 4'd1);
						end
					end
					mi4_pkg::PH_AFF: begin
						if (s_q == 2'd2) begin
							s_d     = '0;
							state_d = mi4_pkg::S_OWAIT;
						end else begin
							s_d = 2'(s_q + 2'd1);
						end
					end
					default: begin
					end
				endcase
			end
			mi4_pkg::S_OSTART: begin
				cmd.cidx = {mi_q[1:0], mi_q[3:2]};
				if (phase_q == mi4_pkg::PH_AFF) begin
					s_d     = '0;
					state_d = (mi_q[1:0] == 2'd3 && mi_q[3:2] != 2'd3) ?
						mi4_pkg::S_RDA : mi4_pkg::S_OWAIT;
				end else begin
					cmd.op  = mi4_pkg::OP_DIV;
					state_d = mi4_pkg::S_DIV;
				end
			end
			mi4_pkg::S_DIV: begin
				if (status.div_done) begin
					state_d = mi4_pkg::S_OWAIT;
				end
			end
			mi4_pkg::S_OWAIT: begin
				cmd.addr = {mi_q[1:0], mi_q[3:2]};
				if (out_free) begin
					cmd.op      = mi4_pkg::OP_OUT;
					out_valid_d = 1'b1;
					if (mi_q == 4'd15) begin
						state_d = mi4_pkg::S_LOAD;
					end else begin
						mi_d    = 4'(mi_q + 4'd1);
						state_d = mi4_pkg::S_OSTART;
					end
				end
			end
			default: begin
				state_d = mi4_pkg::S_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/mi4_dp.sv =====
// Datapath of the 4x4 matrix inverse: element store, minor store, split multiplier,
// saturating accumulators, bit-serial divider and the result register.
// Depends on mi4_pkg; driven by mi4_ctrl through cmd_t.
module mi4_dp #(
	parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  element,
	input  mi4_pkg::cmd_t       cmd,
	output mi4_pkg::status_t    status,
	output logic signed [31:0]  value,
	output logic [1:0]          row,
	output logic [1:0]          column,
	output logic signed [31:0]  determinant,
	output logic                singular,
	output logic                last
);

	localparam int NW = mi4_pkg::MAG_W + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [31:0]        store_q [16];
	logic signed [60:0] cof_q   [16];
	logic [31:0]        rd_data;

	logic signed [31:0] a_q;
	logic signed [60:0] b_q;
	logic [61:0]        pl_q, ph_q;
	logic [91:0]        p_q;
	logic signed [60:0] r_q;
	logic signed [60:0] acc0_q, acc1_q, det_q;

	logic [NW-1:0]      n_q;
	logic [59:0]        d_q, rem_q;
	logic [33:0]        q_q;
	logic               ovf_q, dneg_q;
	logic [CW-1:0]      dcnt_q;

	logic signed [31:0] value_q, det_out_q;
	logic [1:0]         row_q, column_q;
	logic               singular_q, last_q;

	logic [31:0]        ma;
	logic [59:0]        mb;
	logic [92:0]        rsum, rsh;
	logic [59:0]        rmag;
	logic signed [60:0] base, addend, acc_res;
	logic signed [60:0] cof_sel;
	logic [59:0]        cmag, dmag;
	logic [60:0]        remx;
	logic               ge, rnd, big_pos, big_neg;
	logic [34:0]        qr;
	logic signed [31:0] div_val, out_val;

	function automatic logic signed [60:0] sat_add(logic signed [60:0] x, logic signed [60:0] y);
		logic signed [61:0] s;
		logic signed [61:0] lim;
		lim = $signed({2'b00, mi4_pkg::MAG_LIM});
		s   = {x[60], x} + {y[60], y};
		if (s > lim) begin
			return $signed({1'b0, mi4_pkg::MAG_LIM});
		end else if (s < -lim) begin
			return -$signed({1'b0, mi4_pkg::MAG_LIM});
		end
		return s[60:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [60:0] x);
		if (x > 61'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -61'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	assign rd_data = store_q[cmd.addr];
	assign status.div_done = (dcnt_q == '0);

	always_comb begin
		ma   = a_q[31] ? 32'(-a_q) : a_q;
		mb   = b_q[60] ? 60'(-b_q) : b_q[59:0];
		rsum = {1'b0, p_q} + (93'd1 << (FRACTION_BITS - 1));
		rsh  = rsum >> FRACTION_BITS;
		rmag = (|rsh[92:60]) ? mi4_pkg::MAG_LIM : rsh[59:0];

		unique case (cmd.tgt)
			mi4_pkg::T_ACC0: base = acc0_q;
			mi4_pkg::T_ACC1: base = acc1_q;
			default:         base = det_q;
		endcase
		addend  = (cmd.amode == mi4_pkg::A_SUB) ? -r_q : r_q;
		acc_res = (cmd.amode == mi4_pkg::A_SET) ? r_q : sat_add(base, addend);

		cof_sel = cof_q[cmd.cidx];
		cmag    = cof_sel[60] ? 60'(-cof_sel) : cof_sel[59:0];
		dmag    = det_q[60] ? 60'(-det_q) : det_q[59:0];

		remx    = {rem_q, n_q[NW-1]};
		ge      = remx >= {1'b0, d_q};
		rnd     = {rem_q, 1'b0} >= {1'b0, d_q};
		qr      = 35'(q_q) + 35'(rnd);
		big_pos = ovf_q || (qr > 35'd2147483647);
		big_neg = ovf_q || (qr >= 35'd2147483648);
		if (dneg_q) begin
			div_val = big_neg ? 32'sh80000000 : -$signed(qr[31:0]);
		end else begin
			div_val = big_pos ? 32'sh7fffffff : $signed(qr[31:0]);
		end

		if (cmd.aff) begin
			if (cmd.k[3:2] == 2'd3) begin
				out_val = (cmd.k[1:0] == 2'd3) ? (32'sd1 <<< FRACTION_BITS) : 32'sd0;
			end else if (cmd.k[1:0] == 2'd3) begin
				out_val = sat32(-acc0_q);
			end else begin
				out_val = rd_data;
			end
		end else begin
			out_val = (det_q == '0) ? 32'sd0 : div_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.op == mi4_pkg::OP_DIV) begin
			dcnt_q <= CW'(NW);
		end else if (dcnt_q != '0) begin
			dcnt_q <= CW'(dcnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			store_q[cmd.addr] <= element;
		end
		if (dcnt_q != '0) begin
			rem_q <= ge ? 60'(remx - {1'b0, d_q}) : remx[59:0];
			n_q   <= NW'(n_q << 1);
			q_q   <= {q_q[32:0], ge};
			ovf_q <= ovf_q | q_q[33];
		end
		unique case (cmd.op)
			mi4_pkg::OP_RDA: begin
				a_q <= rd_data;
			end
			mi4_pkg::OP_RDB: begin
				unique case (cmd.bsrc)
					mi4_pkg::B_ACC0: b_q <= acc0_q;
					mi4_pkg::B_COF:  b_q <= cof_sel;
					default:         b_q <= {{29{rd_data[31]}}, rd_data};
				endcase
			end
			mi4_pkg::OP_MUL0: begin
				pl_q <= ma * mb[29:0];
			end
			mi4_pkg::OP_MUL1: begin
				ph_q <= ma * mb[59:30];
			end
			mi4_pkg::OP_SUM: begin
				p_q <= 92'(pl_q) + (92'(ph_q) << 30);
			end
			mi4_pkg::OP_RND: begin
				r_q <= (a_q[31] ^ b_q[60]) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
			end
			mi4_pkg::OP_ACC: begin
				unique case (cmd.tgt)
					mi4_pkg::T_ACC0: acc0_q <= acc_res;
					mi4_pkg::T_ACC1: acc1_q <= acc_res;
					default:         det_q  <= acc_res;
				endcase
				if (cmd.cof_we) begin
					cof_q[cmd.cidx] <= acc_res;
				end
			end
			mi4_pkg::OP_DIV: begin
				n_q    <= NW'(cmag) << FRACTION_BITS;
				d_q    <= dmag;
				rem_q  <= '0;
				q_q    <= '0;
				ovf_q  <= 1'b0;
				dneg_q <= cof_sel[60] ^ cmd.cflip ^ det_q[60];
			end
			mi4_pkg::OP_OUT: begin
				value_q    <= out_val;
				row_q      <= cmd.k[3:2];
				column_q   <= cmd.k[1:0];
				last_q     <= (cmd.k == 4'd15);
				det_out_q  <= cmd.aff ? 32'sd0 : sat32(det_q);
				singular_q <= !cmd.aff && (det_q == '0);
			end
			default: begin
			end
		endcase
	end

	assign value       = value_q;
	assign row         = row_q;
	assign column      = column_q;
	assign determinant = det_out_q;
	assign singular    = singular_q;
	assign last        = last_q;

endmodule

// ===== rtl/mi4_checker.sv =====
// Port-level checks for matrix_inverse_4x4 and the bind that attaches them.
// Depends only on the top level's ports.
module mi4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [1:0]  row,
	input logic [1:0]  column,
	input logic [31:0] determinant,
	input logic        singular,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(row)
			&& $stable(column))
		else $error("result request dropped or changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (row == 2'd3 && column == 2'd3)))
		else $error("last does not mark the final element");

	a_sing_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> value == 32'd0)
		else $error("singular matrix gave a nonzero element");

	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> determinant == 32'd0)
		else $error("singular flag with nonzero determinant");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);

// ===== sim/matrix_inverse_4x4_test.sv =====
// Testbench for matrix_inverse_4x4: streams 4x4 Q16.16 matrices in both inverse modes
// and checks every inverse element against a fixed-point predictor held here.
// Depends on mi4_pkg and the matrix_inverse_4x4 RTL only.
module matrix_inverse_4x4_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = mi4_pkg::FRACTION_BITS_DEF;
	localparam longint WIDE_MAX = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
	localparam logic signed [31:0] EMAX = 32'h7FFF_FFFF;
	localparam logic signed [31:0] EMIN = 32'h8000_0000;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         row;
		logic [1:0]         column;
		logic signed [31:0] det;
		logic               singular;
		logic               last;
	} inv_elem_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] element = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic               cfg_data = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [31:0] value;
	logic [1:0]         row;
	logic [1:0]         column;
	logic signed [31:0] determinant;
	logic               singular;
	logic               last;

	inv_elem_t expected_inverse[$];
	longint    loaded[16];
	int        load_index = 0;
	logic      affine_mode = 0;
	int        errors = 0;
	bit        calm = 0;
	bit        hold_req = 0;
	int        quiet_cycles = 0;

	matrix_inverse_4x4 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .element(element),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .value(value), .row(row),
		.column(column), .determinant(determinant), .singular(singular), .last(last)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_wide(longint x);
		if (x > WIDE_MAX) return WIDE_MAX;
		if (x < -WIDE_MAX) return -WIDE_MAX;
		return x;
	endfunction

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > longint'(EMAX)) return EMAX;
		if (x < longint'(EMIN)) return EMIN;
		return 32'(x);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic         neg;
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] s;
		longint       r;
		neg = (a < 0) != (b < 0);
		ma = {64'd0, (a < 0) ? -a : a};
		mb = {64'd0, (b < 0) ? -b : b};
		s = (ma * mb + (128'd1 << (FB - 1))) >> FB;
		if (s > 128'(WIDE_MAX)) s = 128'(WIDE_MAX);
		r = longint'(s[63:0]);
		return neg ? -r : r;
	endfunction

	function automatic logic signed [31:0] fx_div(longint num, longint den);
		logic         neg;
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] rm;
		neg = (num < 0) != (den < 0);
		n = {64'd0, (num < 0) ? -num : num} << FB;
		d = {64'd0, (den < 0) ? -den : den};
		q = n / d;
		rm = n % d;
		if (2 * rm >= d) q = q + 1;
		if (neg) return (q >= 128'h8000_0000) ? EMIN : -32'(q);
		return (q > 128'h7FFF_FFFF) ? EMAX : 32'(q);
	endfunction

	function automatic longint minor_det(int r, int c);
		longint m[9];
		int     k;
		longint t0, t1, t2;
		k = 0;
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++)
				if (y != r && x != c) begin
					m[k] = loaded[y * 4 + x];
					k++;
				end
		t0 = fx_mul(m[0], clamp_wide(fx_mul(m[4], m[8]) - fx_mul(m[5], m[7])));
		t1 = fx_mul(m[1], clamp_wide(fx_mul(m[3], m[8]) - fx_mul(m[5], m[6])));
		t2 = fx_mul(m[2], clamp_wide(fx_mul(m[3], m[7]) - fx_mul(m[4], m[6])));
		return clamp_wide(clamp_wide(t0 - t1) + t2);
	endfunction

	task automatic predict_inverse();
		logic signed [31:0] res[16];
		logic signed [31:0] det_out;
		logic               sing;
		longint             det_w, t, cof, s;
		inv_elem_t          e;
		det_out = 0;
		sing = 0;
		if (!affine_mode) begin
			det_w = 0;
			for (int j = 0; j < 4; j++) begin
				t = fx_mul(loaded[j], minor_det(0, j));
				det_w = clamp_wide((j % 2) ? det_w - t : det_w + t);
			end
			det_out = clamp32(det_w);
			sing = det_w == 0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++) begin
					cof = minor_det(i, j);
					if ((i + j) % 2) cof = -cof;
					res[j * 4 + i] = sing ? 32'sd0 : fx_div(cof, det_w);
				end
		end else begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) res[i * 4 + j] = 32'(loaded[j * 4 + i]);
				s = clamp_wide(fx_mul(loaded[3], loaded[i]) + fx_mul(loaded[7], loaded[4 + i]));
				s = clamp_wide(s + fx_mul(loaded[11], loaded[8 + i]));
				res[i * 4 + 3] = clamp32(-s);
			end
			res[12] = 0;
			res[13] = 0;
			res[14] = 0;
			res[15] = ONE;
		end
		for (int i = 0; i < 16; i++) begin
			e.value = res[i];
			e.row = 2'(i / 4);
			e.column = 2'(i % 4);
			e.det = det_out;
			e.singular = sing;
			e.last = i == 15;
			expected_inverse.push_back(e);
		end
	endtask

	task automatic send_element(input logic signed [31:0] e);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1;
		element <= e;
		do @(posedge clk); while (!in_ready);
		loaded[load_index] = longint'(e);
		load_index = (load_index + 1) % 16;
		if (load_index == 0) predict_inverse();
		@(negedge clk);
	endtask

	task automatic send_matrix(input logic signed [31:0] m[16]);
		for (int k = 0; k < 16; k++) send_element(m[k]);
	endtask

	task automatic drain();
		in_valid <= 0;
		wait (expected_inverse.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		affine_mode = m;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return EMAX;
			1: return EMIN;
			2: return 0;
			3: return 1;
			4: return -1;
			default: return ONE;
		endcase
	endfunction

	function automatic logic signed [31:0] small_fx(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_random_general();
		logic signed [31:0] m[16];
		int kind;
		kind = $urandom_range(0, 4);
		for (int k = 0; k < 16; k++)
			case (kind)
				0: m[k] = $urandom;
				1: m[k] = (k % 5 == 0) ? ONE * $signed($urandom_range(1, 4))
					* ($urandom_range(0, 1) ? 1 : -1) : small_fx(32768);
				2: m[k] = small_fx(1 << 18);
				3: m[k] = (k >= 12) ? m[k - 4] + small_fx(3) : small_fx(1 << 17);
				default: m[k] = pick_extreme();
			endcase
		send_matrix(m);
	endtask

	task automatic send_random_affine();
		logic signed [31:0] m[16];
		for (int k = 0; k < 16; k++)
			if (k % 4 == 3 && k < 12)
				m[k] = $urandom_range(0, 1) ? $urandom : small_fx(1 << 22);
			else if (k >= 12)
				m[k] = (k == 15) ? ONE : ($urandom_range(0, 3) == 0 ? $urandom : 0);
			else
				m[k] = $urandom_range(0, 7) == 0 ? $urandom : small_fx(ONE);
		send_matrix(m);
	endtask

	task automatic test_singular_general();
		logic signed [31:0] m[16];
		for (int k = 0; k < 16; k++) m[k] = (k < 4) ? 0 : pick_extreme();
		m[5] = EMAX;
		m[10] = EMIN;
		send_matrix(m);
		drain();
	endtask

	task automatic test_identity_general();
		logic signed [31:0] m[16];
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE : 0;
		send_matrix(m);
		drain();
	endtask

	task automatic test_affine_extremes();
		logic signed [31:0] m[16];
		write_mode(1);
		for (int k = 0; k < 16; k++) m[k] = (k % 2) ? EMIN : EMAX;
		m[3] = EMAX;
		m[7] = EMAX;
		m[11] = EMIN;
		send_matrix(m);
		drain();
	endtask

	task automatic test_random_general(input int count);
		write_mode(0);
		repeat (count) send_random_general();
		drain();
	endtask

	task automatic test_random_affine(input int count);
		write_mode(1);
		repeat (count) send_random_affine();
		drain();
	endtask

	task automatic test_output_backpressure();
		write_mode(1);
		hold_req = 1;
		repeat (3) send_random_affine();
		drain();
	endtask

	task automatic test_calm_general();
		calm = 1;
		test_random_general(3);
		test_random_affine(1);
		write_mode(0);
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d (%0d left)", field, got, want,
			expected_inverse.size());
		errors++;
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		inv_elem_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_inverse.size() == 0) begin
				$display("unexpected result at row %0d column %0d", row, column);
				errors++;
			end else begin
				e = expected_inverse.pop_front();
				if (value !== e.value) report_mismatch("value", value, e.value);
				if (row !== e.row) report_mismatch("row", row, e.row);
				if (column !== e.column) report_mismatch("column", column, e.column);
				if (determinant !== e.det) report_mismatch("determinant", determinant, e.det);
				if (singular !== e.singular) report_mismatch("singular", singular, e.singular);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_singular_general();
		test_identity_general();
		test_affine_extremes();
		test_random_general(4);
		test_random_affine(3);
		test_output_backpressure();
		test_random_general(4);
		test_calm_general();
		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
